// ===== sv/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, sizes and helpers of the binary search engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int INDEX_W     = 10;
  localparam int KEY_W       = 32;
  // working bounds run from -1 up to 2**INDEX_W, sums up to twice that
  localparam int RANGE_W     = INDEX_W + 2;

  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [RANGE_W-1:0]     range_t;

  typedef struct packed {
    logic                      cmd;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0]   entry_value;
    logic [INDEX_W-1:0]        low_bound;
    logic [INDEX_W-1:0]        high_bound;
    logic signed [KEY_W-1:0]   search_key;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } out_word_t;

  // sign-extend the 32-bit field, then keep the low VALUE_WIDTH bits
  function automatic value_t to_value(logic signed [KEY_W-1:0] field);
    logic signed [63:0] ext;
    ext = 64'(field);
    return ext[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(logic [INDEX_W-1:0] idx);
    logic [31:0] ext;
    ext = 32'(idx);
    return ext[ADDR_W-1:0];
  endfunction

  function automatic logic in_depth(logic [INDEX_W-1:0] idx);
    return 32'(idx) < 32'(DEPTH);
  endfunction

  function automatic range_t to_range(logic [INDEX_W-1:0] idx);
    return signed'({{(RANGE_W-INDEX_W){1'b0}}, idx});
  endfunction

endpackage

`default_nettype wire

// ===== sv/bse_ram.sv =====
// ----------------------------------------------------------------------------
// bse_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/binary_search_engine_top.sv =====
// ----------------------------------------------------------------------------
// binary_search_engine_top
// Binary search over an ascending array held in one on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_word carries either a store (cmd = store: entry_value goes to
//   entry_index, no result) or a search (low_bound, high_bound, search_key).
//   Each search gives exactly one out_word: found and match_index, with
//   match_index zero when the key is not in the range.
//   A store is taken without a stall. A search is accepted, then makes
//   one probe after another, at most floor(log2(high - low + 1)) + 1 probes;
//   an empty range goes to the result without a compare.
//   The single read port of the entry memory sets the pace: each probe reads it
//   and compares, and the next address follows from that compare. One item is
//   in work at a time; in_stall is high while a search runs or a finished
//   result waits for the output register.
//   The output register holds a result while out_stall is high, and the
//   next item is taken as soon as the result has moved there.
//   Reset clears control state only; entries stay undefined until stored.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_search_engine_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bse_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bse_pkg::out_word_t      out_word
);

  import bse_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]          state;
  range_t              low;
  range_t              high;
  value_t              key;
  logic [INDEX_W-1:0]  mid;
  logic                mid_oob;
  logic                found_r;

  logic [VALUE_WIDTH-1:0] rd_data;
  value_t              entry;
  logic                hit;
  logic                less;
  range_t              mid_ext;
  range_t              low_step;
  range_t              high_step;
  range_t              sel_low;
  range_t              sel_high;
  range_t              sum;
  logic [INDEX_W-1:0]  probe_mid;
  logic                range_ok;
  logic                slot_free;
  logic                take_store;
  logic                take_search;
  logic                wr_en;
  logic                rd_en;
  logic                load_out;
  logic                res_found;

  assign in_stall    = state != S_IDLE;
  assign take_store  = state == S_IDLE && in_valid && in_word.cmd == CMD_STORE;
  assign take_search = state == S_IDLE && in_valid && in_word.cmd == CMD_SEARCH;
  assign slot_free   = !out_valid || !out_stall;

  always_comb begin
    // entries past the memory read as zero
    entry     = mid_oob ? '0 : signed'(rd_data);
    hit       = entry == key;
    less      = entry < key;
    mid_ext   = to_range(mid);
    low_step  = less ? mid_ext + range_t'(1) : low;
    high_step = less ? high : mid_ext - range_t'(1);
    if (state == S_IDLE) begin
      sel_low  = to_range(in_word.low_bound);
      sel_high = to_range(in_word.high_bound);
    end else begin
      sel_low  = low_step;
      sel_high = high_step;
    end
    sum       = sel_low + sel_high;
    probe_mid = sum[INDEX_W:1];
    range_ok  = sel_low <= sel_high;
  end

  assign wr_en = take_store && in_depth(in_word.entry_index);
  assign rd_en = take_search || (state == S_LOOK && !hit);

  // a result is ready on a hit, on an exhausted range, or when parked
  assign res_found = (state == S_LOOK) ? hit : found_r;
  assign load_out  = slot_free &&
                     (state == S_WAIT || (state == S_LOOK && (hit || !range_ok)));

  bse_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (to_addr(in_word.entry_index)),
    .wr_data (to_value(in_word.entry_value)),
    .rd_en   (rd_en),
    .rd_addr (to_addr(probe_mid)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take_search) begin
            low     <= sel_low;
            high    <= sel_high;
            key     <= to_value(in_word.search_key);
            mid     <= probe_mid;
            mid_oob <= !in_depth(probe_mid);
            found_r <= 1'b0;
            state   <= range_ok ? S_LOOK : S_WAIT;
          end
        end
        S_LOOK: begin
          if (hit) begin
            found_r <= 1'b1;
            state   <= slot_free ? S_IDLE : S_WAIT;
          end else begin
            low  <= low_step;
            high <= high_step;
            if (range_ok) begin
              mid     <= probe_mid;
              mid_oob <= !in_depth(probe_mid);
            end else begin
              found_r <= 1'b0;
              state   <= slot_free ? S_IDLE : S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid            <= 1'b1;
      out_word.found       <= res_found;
      out_word.match_index <= res_found ? mid : '0;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.found || out_word.match_index == '0)
    else $error("not-found result with nonzero index");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_LOOK || $past(state) == S_WAIT)
    else $error("result loaded outside a search");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |-> low <= high && mid_ext >= low && mid_ext <= high)
    else $error("probe outside the working range");
`endif

endmodule

`default_nettype wire
